@@ hw/rtl/nse_pkg.sv @@
// Shared constants, types and width helpers for the NNUE SCReLU output evaluator.
// No dependencies; imported by every module of the block.
package nse_pkg;

  localparam int VAL_W   = 16;   // accumulator value / weight width
  localparam int TERM_W  = 33;   // clamp^2 (16b unsigned) * weight (16b signed)
  localparam int BIAS_W  = 32;
  localparam int SCORE_W = 29;
  localparam int HIDDEN_LANES_DEF = 512;

  localparam int CLAMP_MAX = 255;
  localparam int OUT_QUANT = 64;

  // per-lane bound of the running sum: 2 terms * 255^2 * 2^15
  localparam longint SUM_UNIT = 64'sd2 * 64'sd65025 * 64'sd32768;

  localparam longint SCORE_MAX = 64'sd268435455;
  localparam longint SCORE_MIN = -64'sd268435456;

  typedef struct packed {
    logic valid;
    logic last;
  } lane_ctl_t;

  typedef struct packed {
    logic pend;    // last item between accumulator and finisher
    logic start;   // final sum handed to finisher this cycle
  } merge_stat_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_LOAD1,
    FS_DIV1,
    FS_SCALE,
    FS_ABS2,
    FS_LOAD2,
    FS_DIV2,
    FS_HOLD
  } fin_state_t;

  // signed width of the saturating running sum for a lane count
  function automatic int sum_width(input int lanes);
    longint lim;
    int w;
    lim = longint'(lanes) * SUM_UNIT;
    w = $clog2(lim + 64'sd1) + 1;
    return (w > TERM_W + 2) ? w : TERM_W + 2;
  endfunction

endpackage

@@ hw/rtl/nse_lane.sv @@
// One evaluation lane: clamp to 0..255, square, multiply by the output weight.
// Two register stages; depends on nse_pkg.
module nse_lane import nse_pkg::*; (
  input  logic                     clk,
  input  logic signed [VAL_W-1:0]  value_i,
  input  logic signed [VAL_W-1:0]  weight_i,
  output logic signed [TERM_W-1:0] term_o
);

  logic [7:0]               clamp;
  logic [15:0]              sq_r;
  logic signed [VAL_W-1:0]  w_r;
  logic signed [TERM_W-1:0] term_r;

  always_comb begin
    if (value_i[VAL_W-1]) begin
      clamp = 8'd0;
    end else if (|value_i[VAL_W-2:8]) begin
      clamp = 8'(CLAMP_MAX);
    end else begin
      clamp = value_i[7:0];
    end
  end

  always_ff @(posedge clk) begin
    sq_r   <= 16'(clamp * clamp);
    w_r    <= weight_i;
    term_r <= $signed({1'b0, sq_r}) * w_r;
  end

  assign term_o = term_r;

endmodule

@@ hw/rtl/nse_merge.sv @@
// Merge stage: adds the two lane terms and folds them into the saturating
// running sum; hands the final sum to the finisher on a last item. Uses nse_pkg.
module nse_merge import nse_pkg::*; #(
  parameter int     SUM_W     = sum_width(HIDDEN_LANES_DEF),
  parameter longint SUM_LIMIT = longint'(HIDDEN_LANES_DEF) * SUM_UNIT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lane_ctl_t                ctl_i,
  input  logic signed [TERM_W-1:0] t_own_i,
  input  logic signed [TERM_W-1:0] t_opp_i,
  output merge_stat_t              stat_o,
  output logic signed [SUM_W-1:0]  sum_o
);

  lane_ctl_t                  ctl3_r;
  logic signed [TERM_W:0]     term_r;
  logic signed [SUM_W-1:0]    acc_r, acc_nxt, acc_sat, fin_sum_r;
  logic signed [SUM_W:0]      acc_ext;
  logic                       start_r;

  always_comb begin
    acc_ext = (SUM_W+1)'(acc_r) + (SUM_W+1)'(term_r);
    if (acc_ext > (SUM_W+1)'(SUM_LIMIT)) begin
      acc_sat = SUM_W'(SUM_LIMIT);
    end else if (acc_ext < (SUM_W+1)'(-SUM_LIMIT)) begin
      acc_sat = SUM_W'(-SUM_LIMIT);
    end else begin
      acc_sat = acc_ext[SUM_W-1:0];
    end
    acc_nxt = acc_r;
    if (ctl3_r.valid) begin
      acc_nxt = ctl3_r.last ? '0 : acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r  <= '0;
      acc_r   <= '0;
      start_r <= 1'b0;
    end else begin
      ctl3_r  <= ctl_i;
      acc_r   <= acc_nxt;
      start_r <= ctl3_r.valid & ctl3_r.last;
    end
  end

  always_ff @(posedge clk) begin
    term_r <= (TERM_W+1)'(t_own_i) + (TERM_W+1)'(t_opp_i);
    if (ctl3_r.valid && ctl3_r.last) begin
      fin_sum_r <= acc_sat;
    end
  end

  assign stat_o.pend  = (ctl3_r.valid & ctl3_r.last) | start_r;
  assign stat_o.start = start_r;
  assign sum_o        = fin_sum_r;

endmodule

@@ hw/rtl/nse_cdiv.sv @@
// Unsigned divider by the constant 255: x = 256*a + b gives x/255 = a + (a + b)/255,
// folded one byte per cycle. Shared by both divisions of the finisher; uses nse_pkg.
module nse_cdiv import nse_pkg::*; #(
  parameter int N = 52
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  output logic         done_o,
  output logic [N-1:0] quot_o
);

  // folds that bring any N-bit dividend below 256, plus one closing step
  localparam int Iter  = (N + 7) / 8 + 1;
  localparam int Steps = Iter + 1;
  localparam int CntW  = $clog2(Steps + 1);

  logic            busy_r, done_r;
  logic [CntW-1:0] cnt_r;
  logic [N-1:0]    rem_r, quo_r, rem_nxt, quo_nxt;
  logic            rem_full;

  always_comb begin
    rem_nxt  = N'(rem_r[N-1:8]) + N'(rem_r[7:0]);
    quo_nxt  = quo_r + N'(rem_r[N-1:8]);
    rem_full = (rem_r == N'(CLAMP_MAX));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CntW'(1));
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(Steps);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= dividend_i;
      quo_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == CntW'(1)) begin
        // remainder is now 0..255; exactly 255 is one more quotient unit
        quo_r <= quo_r + N'(rem_full);
      end else begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
      end
    end
  end

  assign done_o = done_r;
  assign quot_o = quo_r;

endmodule

@@ hw/rtl/nse_finish.sv @@
// Finisher: sum / 255 toward zero, add bias, * 400 / 16320 toward zero,
// saturate to 29 bits, output register. Uses nse_pkg and nse_cdiv.
module nse_finish import nse_pkg::*; #(
  parameter int SUM_W = sum_width(HIDDEN_LANES_DEF)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic signed [SUM_W-1:0]   sum_i,
  input  logic signed [BIAS_W-1:0]  bias_i,
  output logic                      busy_o,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SCORE_W-1:0] out_score
);

  localparam int VW     = ((SUM_W > BIAS_W + 1) ? SUM_W : BIAS_W + 1) + 1;
  localparam int PW     = VW + 9;   // room for * 400
  localparam int DivN   = PW;
  localparam int QShift = $clog2(OUT_QUANT);

  fin_state_t state_r, state_nxt;

  logic                      div_start, out_load;
  logic                      div_done;
  logic [DivN-1:0]           div_quot;

  logic                      neg_r;
  logic [DivN-1:0]           mag_r, p_mag;
  logic signed [VW-1:0]      v_r, q1_s;
  logic signed [PW-1:0]      p_r;
  logic signed [DivN:0]      q2_s, q2_v;
  logic signed [SCORE_W-1:0] res_r, res_nxt;
  logic                      out_valid_r;
  logic signed [SCORE_W-1:0] out_score_r;

  nse_cdiv #(.N(DivN)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (mag_r),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE:  if (start_i) state_nxt = FS_LOAD1;
      FS_LOAD1: state_nxt = FS_DIV1;
      FS_DIV1:  if (div_done) state_nxt = FS_SCALE;
      FS_SCALE: state_nxt = FS_ABS2;
      FS_ABS2:  state_nxt = FS_LOAD2;
      FS_LOAD2: state_nxt = FS_DIV2;
      FS_DIV2:  if (div_done) state_nxt = FS_HOLD;
      FS_HOLD:  if (!out_valid_r || !out_stall) state_nxt = FS_IDLE;
      default:  state_nxt = FS_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      FS_LOAD1: div_start = 1'b1;
      FS_LOAD2: div_start = 1'b1;
      FS_HOLD:  out_load = !out_valid_r || !out_stall;
      default:  ;
    endcase
  end

  always_comb begin
    p_mag = p_r[PW-1] ? $unsigned(-p_r) : $unsigned(p_r);
    q1_s = $signed({1'b0, div_quot[VW-2:0]});
    q2_s = $signed({1'b0, div_quot});
    q2_v = neg_r ? -q2_s : q2_s;
    if (q2_v > (DivN+1)'(SCORE_MAX)) begin
      res_nxt = SCORE_W'(SCORE_MAX);
    end else if (q2_v < (DivN+1)'(SCORE_MIN)) begin
      res_nxt = SCORE_W'(SCORE_MIN);
    end else begin
      res_nxt = q2_v[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      FS_IDLE: begin
        neg_r <= sum_i[SUM_W-1];
        mag_r <= sum_i[SUM_W-1] ? (DivN)'($unsigned(-sum_i)) : (DivN)'($unsigned(sum_i));
      end
      FS_DIV1: begin
        if (div_done) begin
          v_r <= (neg_r ? -q1_s : q1_s) + (VW)'(bias_i);
        end
      end
      // 400 = 256 + 128 + 16
      FS_SCALE: p_r <= ((PW)'(v_r) <<< 8) + ((PW)'(v_r) <<< 7) + ((PW)'(v_r) <<< 4);
      // |p| / 16320 = (|p| / 64) / 255
      FS_ABS2: begin
        neg_r <= p_r[PW-1];
        mag_r <= p_mag >> QShift;
      end
      FS_DIV2: begin
        if (div_done) begin
          res_r <= res_nxt;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_score_r <= res_r;
    end
  end

  assign busy_o    = (state_r != FS_IDLE);
  assign out_valid = out_valid_r;
  assign out_score = out_score_r;

endmodule

@@ hw/rtl/nnue_screlu_output_eval.sv @@
// Output layer of a quantized NNUE with squared clipped ReLU.
// Throughput: one lane item per cycle while in_stall is low; an item with last set closes
// the input until the finisher has parked its score, after two passes through the shared
// divider by 255, whose dividend is PW = sum width + 10 = 52 bits wide at 512 lanes.
// A score's out_valid comes later while an older score waits stalled in the output
// register. Reset (rst_n low, synchronous) clears running sum, bias, pipeline valids
// and out_valid.
module nnue_screlu_output_eval import nse_pkg::*; #(
  parameter int HIDDEN_LANES = HIDDEN_LANES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // bias register
  input  logic                      cfg_wr_en,
  input  logic signed [BIAS_W-1:0]  cfg_wr_data,
  // lane items
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VAL_W-1:0]   in_white_value,
  input  logic signed [VAL_W-1:0]   in_black_value,
  input  logic signed [VAL_W-1:0]   in_own_weight,
  input  logic signed [VAL_W-1:0]   in_opponent_weight,
  input  logic                      in_side_to_move,
  input  logic                      in_last,
  // score items
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SCORE_W-1:0] out_score
);

  // Running-sum width follows the lane count: the sum saturates at
  // HIDDEN_LANES * 2 * 255^2 * 2^15.
  localparam int     SumW     = sum_width(HIDDEN_LANES);
  localparam longint SumLimit = longint'(HIDDEN_LANES) * SUM_UNIT;

  logic                     accept;
  lane_ctl_t                ctl1_r, ctl1_nxt, ctl2_r;
  logic signed [BIAS_W-1:0] bias_r;
  logic signed [VAL_W-1:0]  own_val, opp_val;
  logic signed [TERM_W-1:0] t_own, t_opp;
  merge_stat_t              mstat;
  logic signed [SumW-1:0]   fin_sum;
  logic                     fin_busy;

  assign accept = in_valid && !in_stall;

  // Only one evaluation is in the finishing path at a time: once a last item
  // is taken, hold input until the finisher has parked its score.
  assign in_stall = (ctl1_r.valid & ctl1_r.last) | (ctl2_r.valid & ctl2_r.last)
                  | mstat.pend | fin_busy;

  // side to move picks which perspective feeds the own-weight lane
  assign own_val = in_side_to_move ? in_black_value : in_white_value;
  assign opp_val = in_side_to_move ? in_white_value : in_black_value;

  always_comb begin
    ctl1_nxt.valid = accept;
    ctl1_nxt.last  = accept & in_last;
  end

  // control pipeline runs alongside the two lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      bias_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
      if (cfg_wr_en) begin
        bias_r <= cfg_wr_data;
      end
    end
  end

  nse_lane u_lane_own (
    .clk      (clk),
    .value_i  (own_val),
    .weight_i (in_own_weight),
    .term_o   (t_own)
  );

  nse_lane u_lane_opp (
    .clk      (clk),
    .value_i  (opp_val),
    .weight_i (in_opponent_weight),
    .term_o   (t_opp)
  );

  nse_merge #(.SUM_W(SumW), .SUM_LIMIT(SumLimit)) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl2_r),
    .t_own_i (t_own),
    .t_opp_i (t_opp),
    .stat_o  (mstat),
    .sum_o   (fin_sum)
  );

  nse_finish #(.SUM_W(SumW)) u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (mstat.start),
    .sum_i     (fin_sum),
    .bias_i    (bias_r),
    .busy_o    (fin_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_score (out_score)
  );

endmodule

@@ hw/rtl/nse_checker.sv @@
// Port-level checks for nnue_screlu_output_eval, bound to the top level.
// Depends on nse_pkg for widths.
module nse_checker import nse_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      in_last,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [SCORE_W-1:0] out_score
);

  // a waiting score is neither dropped nor changed
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_score))
    else $error("score changed or dropped under stall");

  // taking a last item closes the input behind it
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input open right after last item");

  // a score only appears at the end of a stalled finishing phase
  a_score_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("score without a finished evaluation");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind nnue_screlu_output_eval nse_checker u_nse_checker (.*);
